### hw/rtl/murmur3_32_stream_hash_core_assert.svh
// Assertion macros for the MurmurHash3 stream hash core.
// Included by the top level; expects clk and rst_n in scope where used.
`ifndef MURMUR3_32_STREAM_HASH_CORE_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define M3H_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define M3H_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/m3h_pkg.sv
// Shared constants, step codes and control structs of the MurmurHash3 core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package m3h_pkg;

  // Hash constants.
  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] STEP_ADD  = 32'he6546b64;
  localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;
  localparam logic [31:0] TWEAK_MUL = 32'hfba4c795;

  // Configuration port geometry and register indexes.
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_SEED_MODE  = 2'd0;
  localparam logic [1:0] REG_PLAIN_SEED = 2'd1;
  localparam logic [1:0] REG_TWEAK      = 2'd2;

  // Datapath step codes issued by the controller.
  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_SEED_PLAIN = 4'd2;
  localparam logic [OP_W-1:0] OP_SEED_MUL   = 4'd3;
  localparam logic [OP_W-1:0] OP_SEED_ADD   = 4'd4;
  localparam logic [OP_W-1:0] OP_KEY_MUL1   = 4'd5;
  localparam logic [OP_W-1:0] OP_KEY_MUL2   = 4'd6;
  localparam logic [OP_W-1:0] OP_KEY_FULL   = 4'd7;
  localparam logic [OP_W-1:0] OP_KEY_TAIL   = 4'd8;
  localparam logic [OP_W-1:0] OP_FIN_MUL1   = 4'd9;
  localparam logic [OP_W-1:0] OP_FIN_MUL2   = 4'd10;
  localparam logic [OP_W-1:0] OP_FIN_OUT    = 4'd11;

  // Command from controller to datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            first;
  } m3h_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_cnt_zero;
    logic in_last;
    logic cnt_zero;
    logic cnt_full;
    logic last;
    logic out_free;
  } m3h_stat_t;

endpackage

`default_nettype wire

### hw/rtl/m3h_if.sv
// Word channels of the MurmurHash3 core: message input and hash output.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface m3h_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;
  logic [31:0] hash_index;

  modport source (output valid, data_word, byte_count, last_word, hash_index,
                  input ready);
  modport sink   (input valid, data_word, byte_count, last_word, hash_index,
                  output ready);
endinterface

interface m3h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/m3h_ctrl.sv
// Sequencing state machine of the MurmurHash3 core.
// Depends on m3h_pkg; drives the datapath through m3h_cmd_t.
`default_nettype none

module m3h_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              seed_mode,
  input  wire m3h_pkg::m3h_stat_t stat,
  output m3h_pkg::m3h_cmd_t      cmd
);
  import m3h_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEED     = 4'd1;
  localparam logic [3:0] ST_SEED_ADD = 4'd2;
  localparam logic [3:0] ST_MIX1     = 4'd3;
  localparam logic [3:0] ST_MIX2     = 4'd4;
  localparam logic [3:0] ST_MIX_UPD  = 4'd5;
  localparam logic [3:0] ST_FIN1     = 4'd6;
  localparam logic [3:0] ST_FIN2     = 4'd7;
  localparam logic [3:0] ST_FOUT     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       mid_r, mid_nxt;
  logic [3:0] after_seed;
  logic [3:0] after_mix;

  // Where a stored word goes once the seed is in place.
  assign after_seed = !stat.cnt_zero ? ST_MIX1 : (stat.last ? ST_FIN1 : ST_IDLE);
  assign after_mix  = stat.last ? ST_FIN1 : ST_IDLE;

  // Next state and step selection.
  always_comb begin
    state_nxt = state_r;
    mid_nxt   = mid_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.first = !mid_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op  = OP_LOAD;
          mid_nxt = 1'b1;
          if (!mid_r) begin
            state_nxt = ST_SEED;
          end else if (!stat.in_cnt_zero) begin
            state_nxt = ST_MIX1;
          end else if (stat.in_last) begin
            state_nxt = ST_FIN1;
          end
        end
      end
      ST_SEED: begin
        if (seed_mode) begin
          cmd.op    = OP_SEED_MUL;
          state_nxt = ST_SEED_ADD;
        end else begin
          cmd.op    = OP_SEED_PLAIN;
          state_nxt = after_seed;
        end
      end
      ST_SEED_ADD: begin
        cmd.op    = OP_SEED_ADD;
        state_nxt = after_seed;
      end
      ST_MIX1: begin
        cmd.op    = OP_KEY_MUL1;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.op    = OP_KEY_MUL2;
        state_nxt = ST_MIX_UPD;
      end
      ST_MIX_UPD: begin
        cmd.op    = stat.cnt_full ? OP_KEY_FULL : OP_KEY_TAIL;
        state_nxt = after_mix;
      end
      ST_FIN1: begin
        cmd.op    = OP_FIN_MUL1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op    = OP_FIN_MUL2;
        state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        // Hold until the output register can take the hash.
        if (stat.out_free) begin
          cmd.op    = OP_FIN_OUT;
          mid_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mid_r   <= mid_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/m3h_dpath.sv
// Datapath of the MurmurHash3 core: word capture, one shared multiplier,
// hash and length registers, and the output register. Depends on m3h_pkg.
`default_nettype none

module m3h_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire m3h_pkg::m3h_cmd_t  cmd,
  output m3h_pkg::m3h_stat_t      stat,
  input  wire logic [31:0]        in_data_word,
  input  wire logic [2:0]         in_byte_count,
  input  wire logic               in_last_word,
  input  wire logic [31:0]        in_hash_index,
  input  wire logic [31:0]        plain_seed,
  input  wire logic [31:0]        tweak_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_hash_value
);
  import m3h_pkg::*;

  logic [31:0] word_r, word_nxt;
  logic [2:0]  cnt_r, cnt_sat;
  logic        last_r;
  logic [31:0] index_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] h_x, h_rot, fin_x;

  // Saturate the byte count and mask off unused bytes.
  assign cnt_sat = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  always_comb begin
    case (cnt_sat)
      3'd0:    word_nxt = 32'h0;
      3'd1:    word_nxt = {24'h0, in_data_word[7:0]};
      3'd2:    word_nxt = {16'h0, in_data_word[15:0]};
      3'd3:    word_nxt = {8'h0, in_data_word[23:0]};
      default: word_nxt = in_data_word;
    endcase
  end

  // Operand selection for the shared multiplier.
  assign fin_x = (h_r ^ total_r) ^ ((h_r ^ total_r) >> 16);
  always_comb begin
    case (cmd.op)
      OP_SEED_MUL: begin
        mul_a = index_r;
        mul_b = TWEAK_MUL;
      end
      OP_KEY_MUL2: begin
        mul_a = {k_r[16:0], k_r[31:17]};
        mul_b = MIX_C2;
      end
      OP_FIN_MUL1: begin
        mul_a = fin_x;
        mul_b = FIN_C1;
      end
      OP_FIN_MUL2: begin
        mul_a = k_r ^ (k_r >> 13);
        mul_b = FIN_C2;
      end
      default: begin
        mul_a = word_r;
        mul_b = MIX_C1;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Full-word state update: xor, rotate by 13, times five plus constant.
  assign h_x   = h_r ^ k_r;
  assign h_rot = {h_x[18:0], h_x[31:19]};

  // Register updates per step.
  always_comb begin
    h_nxt         = h_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op) inside
      OP_LOAD:       total_nxt = (cmd.first ? 32'h0 : total_r) + {29'h0, cnt_sat};
      OP_SEED_PLAIN: h_nxt = plain_seed;
      OP_SEED_ADD:   h_nxt = k_r + tweak_value;
      OP_KEY_FULL:   h_nxt = (h_rot << 2) + h_rot + STEP_ADD;
      OP_KEY_TAIL:   h_nxt = h_x;
      OP_SEED_MUL, OP_KEY_MUL1, OP_KEY_MUL2, OP_FIN_MUL1, OP_FIN_MUL2: begin
        k_nxt = mul_p;
      end
      OP_FIN_OUT: begin
        out_hash_nxt  = k_r ^ (k_r >> 16);
        out_valid_nxt = 1'b1;
      end
      default: begin
        h_nxt = h_r;
      end
    endcase
  end

  // Control register: output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      word_r  <= word_nxt;
      cnt_r   <= cnt_sat;
      last_r  <= in_last_word;
      index_r <= in_hash_index;
    end
    h_r        <= h_nxt;
    k_r        <= k_nxt;
    total_r    <= total_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // Status to the controller.
  assign stat.in_cnt_zero = (cnt_sat == 3'd0);
  assign stat.in_last     = in_last_word;
  assign stat.cnt_zero    = (cnt_r == 3'd0);
  assign stat.cnt_full    = (cnt_r == 3'd4);
  assign stat.last        = last_r;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

`default_nettype wire

### hw/rtl/murmur3_32_stream_hash_core.sv
// Top level of the streaming MurmurHash3 (x86_32) core: APB-style register
// bank, controller and datapath. Depends on m3h_pkg, m3h_if, m3h_ctrl, m3h_dpath.
//
//   Channel   Direction  Handshake        Word contents
//   in_if     in         valid / ready    data_word, byte_count, last_word, hash_index
//   out_if    out        valid / ready    hash_value
//   APB       in         psel / penable   seed_mode, plain_seed, tweak_value
//
// One word at a time: the shared multiplier sets the pace. A nonempty word is loaded,
// multiplied twice and mixed in; a message's first word also sets the seed (plain,
// or tweak multiply and add); a last word is finalised before its hash is registered
// at the output. The output register frees the input side while a hash waits; a new
// hash waits for the previous one to be taken. Reset is synchronous, active low.
`default_nettype none

module murmur3_32_stream_hash_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  m3h_in_if.sink                           in_if,
  m3h_out_if.source                        out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [m3h_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import m3h_pkg::*;

  logic        seed_mode_r;
  logic [31:0] plain_seed_r;
  logic [31:0] tweak_r;
  logic        wr_en;
  m3h_cmd_t    cmd;
  m3h_stat_t   stat;

  // Register writes at the access cycle.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_mode_r  <= 1'b0;
      plain_seed_r <= 32'h0;
      tweak_r      <= 32'h0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SEED_MODE:  seed_mode_r  <= pwdata[0];
        REG_PLAIN_SEED: plain_seed_r <= pwdata;
        REG_TWEAK:      tweak_r      <= pwdata;
        default:        seed_mode_r  <= seed_mode_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      REG_SEED_MODE:  prdata = {31'h0, seed_mode_r};
      REG_PLAIN_SEED: prdata = plain_seed_r;
      REG_TWEAK:      prdata = tweak_r;
      default:        prdata = 32'h0;
    endcase
  end

  // Sequencer.
  m3h_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .seed_mode (seed_mode_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  m3h_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_data_word   (in_if.data_word),
    .in_byte_count  (in_if.byte_count),
    .in_last_word   (in_if.last_word),
    .in_hash_index  (in_if.hash_index),
    .plain_seed     (plain_seed_r),
    .tweak_value    (tweak_r),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_hash_value (out_if.hash_value)
  );

  // Checks.
`include "murmur3_32_stream_hash_core_assert.svh"

  `M3H_ASSERT_IMP(a_out_backpressure, cmd.op == OP_FIN_OUT, stat.out_free, "hash overrun")
  `M3H_ASSERT_IMP(a_accept_loads, in_if.valid && in_if.ready, cmd.op == OP_LOAD, "word dropped")
  `M3H_ASSERT_NXT(a_out_source, cmd.op == OP_FIN_OUT, out_if.valid, "hash not presented")

endmodule

`default_nettype wire

### dv/murmur3_32_stream_hash_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming MurmurHash3 (x86_32) core.
// Depends on m3h_pkg, the m3h_in_if / m3h_out_if channels and the core RTL.

module murmur3_32_stream_hash_core_tb;
  import m3h_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_WORDS   = 185;
  localparam int unsigned NUM_PHASES    = 4;

  // One message word as presented on the input channel.
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic [31:0] hash_index;
  } msg_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  m3h_in_if  in_if ();
  m3h_out_if out_if ();

  murmur3_32_stream_hash_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, and hashes the core still owes us.
  msg_word_t   word_queue[$];
  logic [31:0] hash_queue[$];

  // Predictor copy of the register bank and of the core's running state.
  logic        cfg_seed_mode;
  logic [31:0] cfg_plain_seed;
  logic [31:0] cfg_tweak;
  logic [31:0] run_hash;
  logic [31:0] run_bytes;
  logic        in_message;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_queued;
  int unsigned words_accepted;
  int unsigned messages_queued;
  int unsigned hashes_checked;
  int unsigned fail_count;
  int unsigned cycle_count;
  logic        in_taken;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_key(input logic [31:0] k);
    logic [31:0] t;
    t = k * MIX_C1;
    t = rotl32(t, 15);
    return t * MIX_C2;
  endfunction

  function automatic logic [31:0] finalize_hash(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FIN_C1;
    t = t ^ (t >> 13);
    t = t * FIN_C2;
    return t ^ (t >> 16);
  endfunction

  // Advance the predicted hash state by one accepted word.
  task automatic absorb_word(input msg_word_t w);
    int unsigned nbytes;
    logic [31:0] mask;
    nbytes = (w.byte_count > 3'd4) ? 4 : int'(w.byte_count);
    if (!in_message) begin
      run_hash   = cfg_seed_mode ? (w.hash_index * TWEAK_MUL + cfg_tweak) : cfg_plain_seed;
      run_bytes  = '0;
      in_message = 1'b1;
    end
    if (nbytes == 4) begin
      run_hash = run_hash ^ scramble_key(w.data_word);
      run_hash = rotl32(run_hash, 13);
      run_hash = run_hash * 32'd5 + STEP_ADD;
    end else if (nbytes != 0) begin
      mask     = 32'hffffffff >> (8 * (4 - nbytes));
      run_hash = run_hash ^ scramble_key(w.data_word & mask);
    end
    run_bytes = run_bytes + nbytes;
    if (w.last_word) begin
      hash_queue.push_back(finalize_hash(run_hash ^ run_bytes));
      in_message = 1'b0;
    end
  endtask

  task automatic queue_word(input logic [31:0] data, input logic [2:0] count,
                            input logic last, input logic [31:0] index);
    word_queue.push_back('{data_word: data, byte_count: count, last_word: last,
                           hash_index: index});
    words_queued++;
    if (last) messages_queued++;
  endtask

  // Mostly well-formed messages with random content; the rest carry odd counts
  // and partial or empty words in the middle of a message.
  task automatic queue_random_message();
    int unsigned nwords;
    if ($urandom_range(99) < 80) begin
      nwords = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      repeat (nwords) queue_word($urandom, 3'd4, 1'b0, $urandom);
      queue_word($urandom, 3'($urandom_range(0, 4)), 1'b1, $urandom);
    end else begin
      nwords = $urandom_range(1, 5);
      for (int unsigned i = 1; i <= nwords; i++)
        queue_word($urandom, 3'($urandom_range(0, 7)), i == nwords, $urandom);
    end
  endtask

  // Register write followed by a read back of the same register.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    string       reg_name;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    if (pready !== 1'b1) begin
      $error("pready: expected 1, got %b", pready);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SEED_MODE: begin
        cfg_seed_mode = value[0];
        want          = {31'd0, value[0]};
        reg_name      = "seed_mode";
      end
      REG_PLAIN_SEED: begin
        cfg_plain_seed = value;
        want           = value;
        reg_name       = "plain_seed";
      end
      default: begin
        cfg_tweak = value;
        want      = value;
        reg_name  = "tweak_value";
      end
    endcase
    if (readback !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", reg_name, want, readback);
      fail_count++;
    end
  endtask

  // Wait until every queued word is taken and every hash has come back.
  task automatic drain();
    while (words_accepted != words_queued || hash_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: offers the next word once the previous one has been taken.
  always @(negedge clk) begin : drive_words
    msg_word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_queue.pop_front();
        in_if.valid      <= 1'b1;
        in_if.data_word  <= w.data_word;
        in_if.byte_count <= w.byte_count;
        in_if.last_word  <= w.last_word;
        in_if.hash_index <= w.hash_index;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: checks hashes against the predictor, then feeds it accepted words.
  always @(posedge clk) begin : watch_channels
    logic [31:0] want;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (hash_queue.size() == 0) begin
          $error("hash_value: expected none pending, got 0x%08h", out_if.hash_value);
          fail_count++;
        end else begin
          want = hash_queue.pop_front();
          hashes_checked++;
          if (out_if.hash_value !== want) begin
            $error("hash_value: expected 0x%08h, got 0x%08h", want, out_if.hash_value);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        words_accepted++;
        absorb_word({in_if.data_word, in_if.byte_count, in_if.last_word, in_if.hash_index});
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sequencer: reset, then one phase per seed setting and idle mix.
  initial begin
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.data_word  = '0;
    in_if.byte_count = '0;
    in_if.last_word  = 1'b0;
    in_if.hash_index = '0;
    out_if.ready     = 1'b0;
    in_taken         = 1'b0;
    cfg_seed_mode    = 1'b0;
    cfg_plain_seed   = '0;
    cfg_tweak        = '0;
    run_hash         = '0;
    run_bytes        = '0;
    in_message       = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    words_queued     = 0;
    words_accepted   = 0;
    messages_queued  = 0;
    hashes_checked   = 0;
    fail_count       = 0;
    cycle_count      = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          reg_write(REG_SEED_MODE, 32'd0);
          reg_write(REG_PLAIN_SEED, 32'h00000000);
          reg_write(REG_TWEAK, 32'h00000000);
        end
        1: begin
          reg_write(REG_SEED_MODE, 32'd1);
          reg_write(REG_TWEAK, 32'hffffffff);
        end
        2: begin
          reg_write(REG_SEED_MODE, 32'd0);
          reg_write(REG_PLAIN_SEED, 32'hffffffff);
        end
        default: begin
          reg_write(REG_SEED_MODE, 32'hfffffffe | 32'd1);
          reg_write(REG_PLAIN_SEED, $urandom);
          reg_write(REG_TWEAK, $urandom);
        end
      endcase

      @(posedge clk);
      send_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 21 : 0;
      recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 21 : 0;

      if (phase == 0) begin
        // Empty message, short tails with junk in the unused bytes, and full words.
        queue_word(32'hffffffff, 3'd0, 1'b1, 32'h0);
        queue_word(32'hffffffff, 3'd1, 1'b1, 32'h0);
        queue_word(32'hffffffff, 3'd2, 1'b1, 32'h0);
        queue_word(32'hffffffff, 3'd3, 1'b1, 32'h0);
        queue_word(32'h00000000, 3'd4, 1'b1, 32'h0);
        queue_word(32'hffffffff, 3'd4, 1'b0, 32'h0);
        queue_word(32'hffffffff, 3'd4, 1'b1, 32'h0);
        // Counts above four saturate to a full word.
        queue_word(32'hffffffff, 3'd7, 1'b1, 32'h0);
        queue_word(32'h12345678, 3'd5, 1'b0, 32'h0);
        queue_word(32'ha5a5a5a5, 3'd6, 1'b1, 32'h0);
        // Partial and empty words in the middle of a message.
        queue_word(32'hffffffff, 3'd2, 1'b0, 32'h0);
        queue_word(32'h80000001, 3'd4, 1'b0, 32'h0);
        queue_word(32'hffffffff, 3'd3, 1'b1, 32'h0);
        queue_word(32'hffffffff, 3'd0, 1'b0, 32'h0);
        queue_word(32'hdeadbeef, 3'd1, 1'b1, 32'h0);
        queue_word(32'h00000000, 3'd4, 1'b0, 32'h0);
        queue_word(32'h00000000, 3'd0, 1'b1, 32'h0);
      end else if (phase == 1) begin
        // Hash index extremes; only the first word's index may count.
        queue_word(32'h0, 3'd0, 1'b1, 32'h00000000);
        queue_word(32'hffffffff, 3'd4, 1'b1, 32'hffffffff);
        queue_word(32'h01020304, 3'd4, 1'b0, 32'hffffffff);
        queue_word(32'hffffffff, 3'd2, 1'b1, 32'h00000000);
      end

      while (words_queued < (phase + 1) * PHASE_WORDS) queue_random_message();
      drain();
    end

    $display("Sent %0d words in %0d messages over %0d seed settings and idle mixes.",
             words_queued, messages_queued, NUM_PHASES);
    $display("Checked %0d hashes; %0d mismatches.", hashes_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/m3h_pkg.sv
hw/rtl/m3h_if.sv
hw/rtl/m3h_ctrl.sv
hw/rtl/m3h_dpath.sv
hw/rtl/murmur3_32_stream_hash_core.sv
dv/murmur3_32_stream_hash_core_tb.sv
